### design/rmm_pkg.sv
// Shared types and constants for the running median min/max monitor.
`timescale 1ns / 1ps

package rmm_pkg;

   // Command group from the sequencer to the sorting cell row
   typedef struct packed {
      logic clear;     // empty the sorted row
      logic insert;    // insert the presented value in order
      logic pick_hi;   // capture the upper middle entry
      logic pick_lo;   // form the median from the middle entries
   } rmm_sort_ctl_type;

   localparam int unsigned CFG_WIDTH = 6;
   localparam int unsigned COUNT_BITS = 32;
   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 6'd32;

endpackage

### design/rmm_ring_ram.sv
// Ring storage: single write port, single registered read port.
`timescale 1ns / 1ps

module rmm_ring_ram
   import rmm_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data available in the following cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rmm_sort_cells.sv
// Row of sorting cells: ordered insertion of window samples and median pick.
`timescale 1ns / 1ps

module rmm_sort_cells
   import rmm_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int PTR_W = 5,
   parameter int CNT_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rmm_sort_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0] ins_value,
   input  logic        [CNT_W-1:0]       win_len,
   output logic signed [SAMPLE_BITS-1:0] median
);

   logic signed [SAMPLE_BITS-1:0] cell_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] cell_in [DEPTH];
   logic signed [SAMPLE_BITS-1:0] prev_cell [DEPTH];
   logic        [DEPTH-1:0]       gt;
   logic        [DEPTH-1:0]       prev_le;
   logic        [CNT_W-1:0]       sort_cnt_ff;
   logic        [CNT_W-1:0]       sort_cnt_in;
   logic signed [SAMPLE_BITS-1:0] mid_ff;
   logic signed [SAMPLE_BITS-1:0] med_ff;
   logic signed [SAMPLE_BITS-1:0] lo_val;
   logic signed [SAMPLE_BITS:0]   mid_sum;
   logic        [PTR_W-1:0]       half;
   logic        [PTR_W-1:0]       lo_idx;

   // Compare the new value against every occupied cell; empty cells count as larger
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) >= sort_cnt_ff) || (cell_ff[i] > ins_value);
      end
      prev_cell[0] = ins_value;
      prev_le[0]   = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         prev_cell[i] = cell_ff[i-1];
         prev_le[i]   = !gt[i-1];
      end
   end

   // Keep cells not larger than the value, put the value at the boundary, shift the rest up
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (!gt[i]) begin
            cell_in[i] = cell_ff[i];
         end else if (prev_le[i]) begin
            cell_in[i] = ins_value;
         end else begin
            cell_in[i] = prev_cell[i];
         end
      end
   end

   always_comb begin
      sort_cnt_in = sort_cnt_ff;
      if (ctl.clear) begin
         sort_cnt_in = '0;
      end else if (ctl.insert) begin
         sort_cnt_in = sort_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_cnt_ff <= '0;
      end else begin
         sort_cnt_ff <= sort_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert) begin
         cell_ff <= cell_in;
      end
   end

   // Middle positions of the sorted window
   assign half    = PTR_W'(win_len >> 1);
   assign lo_idx  = (half == '0) ? '0 : half - PTR_W'(1);
   assign lo_val  = cell_ff[lo_idx];
   assign mid_sum = {mid_ff[SAMPLE_BITS-1], mid_ff} + {lo_val[SAMPLE_BITS-1], lo_val};

   // Capture the upper middle, then average for an even length (floor)
   always_ff @(posedge clock) begin
      if (ctl.pick_hi) begin
         mid_ff <= cell_ff[half];
      end
      if (ctl.pick_lo) begin
         med_ff <= win_len[0] ? mid_ff : mid_sum[SAMPLE_BITS:1];
      end
   end

   assign median = med_ff;

endmodule

### design/running_median_minmax_monitor.sv
// Top level: sequencer, ring scans, extremes and result register.
// Order: accept in idle, scan, ST_MED_A and ST_MED_B when a median is due, then ST_DONE until
// the result beat loads; the scan reads L = max(window entries, median ring entries read),
// at most the effective window length. A new sample is stalled until the beat loads; the scan
// walks each ring's one read port one entry per cycle, with both rings read in parallel.
// Reset (synchronous): clears pointers, counts and state; long-term extremes go to their
// limits and window_size to 32. Ring contents are not cleared.
`timescale 1ns / 1ps

module running_median_minmax_monitor
   import rmm_pkg::*;
#(
   parameter int WINDOW_DEPTH = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [CFG_WIDTH-1:0]   csr_window_size,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_median_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_value,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_ring_min,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_ring_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_longterm_min,
   output logic signed [SAMPLE_BITS-1:0] rsp_longterm_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_longterm_median_min,
   output logic signed [SAMPLE_BITS-1:0] rsp_longterm_median_max,
   output logic        [COUNT_BITS-1:0]  rsp_samples_seen
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_MED_A = 3'd2;
   localparam logic [2:0] ST_MED_B = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CFG_WIDTH-1:0]          win_ff;
   logic [CNT_W-1:0]              n_eff;
   logic [CNT_W-1:0]              n_ff;
   logic [PTR_W-1:0]              swp_ff, mwp_ff;
   logic [PTR_W-1:0]              s_addr_ff, m_addr_ff;
   logic [CNT_W-1:0]              fill_ff, fill_nx;
   logic [COUNT_BITS-1:0]         total_ff, total_in;
   logic                          due_in, due_ff;
   logic [CNT_W-1:0]              cnt_s_in, cnt_s_ff;
   logic [CNT_W-1:0]              mfill, kk, k_in, k_ff;
   logic [CNT_W-1:0]              len_in, len_ff;
   logic [CNT_W-1:0]              iss_ff;
   logic                          s_issue, m_issue;
   logic                          s_vld_ff, m_vld_ff;
   logic                          accept, load;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        s_rdata, m_rdata;
   logic signed [SAMPLE_BITS-1:0] s_val, m_val;
   logic signed [SAMPLE_BITS-1:0] wmin_ff, wmax_ff, rmin_ff, rmax_ff;
   logic signed [SAMPLE_BITS-1:0] lt_raw_min_ff, lt_raw_max_ff;
   logic signed [SAMPLE_BITS-1:0] lt_med_min_ff, lt_med_max_ff;
   logic signed [SAMPLE_BITS-1:0] lt_med_min_in, lt_med_max_in;
   logic signed [SAMPLE_BITS-1:0] ring_min_in, ring_max_in;
   logic signed [SAMPLE_BITS-1:0] median;
   rmm_sort_ctl_type              sort_ctl;

   logic                          o_mvld_ff;
   logic signed [SAMPLE_BITS-1:0] o_med_ff, o_wmin_ff, o_wmax_ff, o_rmin_ff, o_rmax_ff;
   logic signed [SAMPLE_BITS-1:0] o_ltmin_ff, o_ltmax_ff, o_ltmmin_ff, o_ltmmax_ff;
   logic [COUNT_BITS-1:0]         o_seen_ff;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Effective window length: zero acts as one, saturate at the ring depth
   always_comb begin
      if (win_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(win_ff) > 32'(WINDOW_DEPTH)) begin
         n_eff = DEPTH_CNT;
      end else begin
         n_eff = CNT_W'(win_ff);
      end
   end

   // Per-sample counts worked out at acceptance
   always_comb begin
      total_in = (total_ff == '1) ? total_ff : total_ff + COUNT_BITS'(1);
      due_in   = (total_in >= COUNT_BITS'(n_eff));
      cnt_s_in = due_in ? n_eff : CNT_W'(total_in);
      fill_nx  = (fill_ff < DEPTH_CNT) ? fill_ff + CNT_W'(1) : fill_ff;
      mfill    = due_in ? fill_nx : fill_ff;
      kk       = (mfill < n_eff) ? mfill : n_eff;
      k_in     = due_in ? kk - CNT_W'(1) : kk;
      len_in   = (cnt_s_in > k_in) ? cnt_s_in : k_in;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff == len_ff) begin
               state_in = due_ff ? ST_MED_A : ST_DONE;
            end
         end
         ST_MED_A: state_in = ST_MED_B;
         ST_MED_B: state_in = ST_DONE;
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign s_issue = (state_ff == ST_SCAN) && (iss_ff < cnt_s_ff);
   assign m_issue = (state_ff == ST_SCAN) && (iss_ff < k_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_ff        <= WINDOW_RESET;
         swp_ff        <= '0;
         mwp_ff        <= '0;
         fill_ff       <= '0;
         total_ff      <= '0;
         iss_ff        <= '0;
         s_vld_ff      <= 1'b0;
         m_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lt_raw_min_ff <= S_MAX;
         lt_raw_max_ff <= S_MIN;
         lt_med_min_ff <= S_MAX;
         lt_med_max_ff <= S_MIN;
      end else begin
         state_ff     <= state_in;
         s_vld_ff     <= s_issue;
         m_vld_ff     <= m_issue;
         rsp_valid_ff <= load || (rsp_valid_ff && rsp_stall);
         if (csr_valid && csr_ready) begin
            win_ff <= csr_window_size;
         end
         if (accept) begin
            swp_ff   <= (swp_ff == LAST_IDX) ? '0 : swp_ff + PTR_W'(1);
            total_ff <= total_in;
            iss_ff   <= '0;
            if (req_sample < lt_raw_min_ff) begin
               lt_raw_min_ff <= req_sample;
            end
            if (req_sample > lt_raw_max_ff) begin
               lt_raw_max_ff <= req_sample;
            end
         end else if ((state_ff == ST_SCAN) && (iss_ff < len_ff)) begin
            iss_ff <= iss_ff + CNT_W'(1);
         end
         // Push the median and fold it into the long-term extremes
         if (load && due_ff) begin
            mwp_ff        <= (mwp_ff == LAST_IDX) ? '0 : mwp_ff + PTR_W'(1);
            fill_ff       <= fill_nx;
            lt_med_min_ff <= lt_med_min_in;
            lt_med_max_ff <= lt_med_max_in;
         end
      end
   end

   // Scan set-up and read address walk, newest entry first
   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff      <= n_eff;
         due_ff    <= due_in;
         cnt_s_ff  <= cnt_s_in;
         k_ff      <= k_in;
         len_ff    <= len_in;
         s_addr_ff <= swp_ff;
         m_addr_ff <= (mwp_ff == '0) ? LAST_IDX : mwp_ff - PTR_W'(1);
      end else begin
         if (s_issue) begin
            s_addr_ff <= (s_addr_ff == '0) ? LAST_IDX : s_addr_ff - PTR_W'(1);
         end
         if (m_issue) begin
            m_addr_ff <= (m_addr_ff == '0) ? LAST_IDX : m_addr_ff - PTR_W'(1);
         end
      end
   end

   rmm_ring_ram #(
      .DEPTH  (WINDOW_DEPTH),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (PTR_W)
   ) u_sample_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (swp_ff),
      .wr_data (req_sample),
      .rd_en   (s_issue),
      .rd_addr (s_addr_ff),
      .rd_data (s_rdata)
   );

   rmm_ring_ram #(
      .DEPTH  (WINDOW_DEPTH),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (PTR_W)
   ) u_median_ring (
      .clock   (clock),
      .wr_en   (load && due_ff),
      .wr_addr (mwp_ff),
      .wr_data (median),
      .rd_en   (m_issue),
      .rd_addr (m_addr_ff),
      .rd_data (m_rdata)
   );

   assign s_val = $signed(s_rdata);
   assign m_val = $signed(m_rdata);

   // Accumulate window and median ring extremes as read data returns
   always_ff @(posedge clock) begin
      if (accept) begin
         wmin_ff <= S_MAX;
         wmax_ff <= S_MIN;
         rmin_ff <= S_MAX;
         rmax_ff <= S_MIN;
      end else begin
         if (s_vld_ff) begin
            if (s_val < wmin_ff) begin
               wmin_ff <= s_val;
            end
            if (s_val > wmax_ff) begin
               wmax_ff <= s_val;
            end
         end
         if (m_vld_ff) begin
            if (m_val < rmin_ff) begin
               rmin_ff <= m_val;
            end
            if (m_val > rmax_ff) begin
               rmax_ff <= m_val;
            end
         end
      end
   end

   // Drive the sorting row
   always_comb begin
      sort_ctl.clear   = accept;
      sort_ctl.insert  = s_vld_ff && due_ff;
      sort_ctl.pick_hi = (state_ff == ST_MED_A);
      sort_ctl.pick_lo = (state_ff == ST_MED_B);
   end

   rmm_sort_cells #(
      .DEPTH       (WINDOW_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .PTR_W       (PTR_W),
      .CNT_W       (CNT_W)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sort_ctl),
      .ins_value (s_val),
      .win_len   (n_ff),
      .median    (median)
   );

   // Final extremes, including the new median when one is due; an empty median ring reads as zero
   always_comb begin
      lt_med_min_in = (median < lt_med_min_ff) ? median : lt_med_min_ff;
      lt_med_max_in = (median > lt_med_max_ff) ? median : lt_med_max_ff;
      if (due_ff) begin
         ring_min_in = (median < rmin_ff) ? median : rmin_ff;
         ring_max_in = (median > rmax_ff) ? median : rmax_ff;
      end else if (fill_ff == '0) begin
         ring_min_in = '0;
         ring_max_in = '0;
      end else begin
         ring_min_in = rmin_ff;
         ring_max_in = rmax_ff;
      end
   end

   // Result register: load the beat once the previous one has gone
   always_ff @(posedge clock) begin
      if (load) begin
         o_mvld_ff   <= due_ff;
         o_med_ff    <= due_ff ? median : '0;
         o_wmin_ff   <= wmin_ff;
         o_wmax_ff   <= wmax_ff;
         o_rmin_ff   <= ring_min_in;
         o_rmax_ff   <= ring_max_in;
         o_ltmin_ff  <= lt_raw_min_ff;
         o_ltmax_ff  <= lt_raw_max_ff;
         o_ltmmin_ff <= due_ff ? lt_med_min_in : lt_med_min_ff;
         o_ltmmax_ff <= due_ff ? lt_med_max_in : lt_med_max_ff;
         o_seen_ff   <= total_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_median_valid        = o_mvld_ff;
   assign rsp_median_value        = o_med_ff;
   assign rsp_window_min          = o_wmin_ff;
   assign rsp_window_max          = o_wmax_ff;
   assign rsp_median_ring_min     = o_rmin_ff;
   assign rsp_median_ring_max     = o_rmax_ff;
   assign rsp_longterm_min        = o_ltmin_ff;
   assign rsp_longterm_max        = o_ltmax_ff;
   assign rsp_longterm_median_min = o_ltmmin_ff;
   assign rsp_longterm_median_max = o_ltmmax_ff;
   assign rsp_samples_seen        = o_seen_ff;

   // Checks
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= len_ff))
      else $error("scan counter ran past its length");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("median fill count above ring depth");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted sample did not start a scan");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_min <= rsp_window_max))
      else $error("window extremes out of order");

endmodule
